>>> rtl/core/square_to_quad_homography_macros.svh
// Assertion macros used by the RTL top level
`ifndef SQUARE_TO_QUAD_HOMOGRAPHY_MACROS_SVH
`define SQUARE_TO_QUAD_HOMOGRAPHY_MACROS_SVH

// hold b whenever a holds
`define SQH_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// hold b in the cycle after a
`define SQH_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/core/sqh_pkg.sv
package sqh_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int RES_W       = COORD_W + 2;
    localparam int PROD_W      = 2 * COORD_W + 4;
    localparam int THR_W       = 15;
    localparam int COEF_W      = 32;
    localparam int DIV_REM_W   = PROD_W + 32;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_LAT     = DIV_STEPS + 2;
    localparam int PQ_W        = COEF_W + COORD_W;
    localparam int SUM_W       = PQ_W + 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] lt_x;
        logic signed [COORD_W-1:0] lt_y;
        logic signed [COORD_W-1:0] rt_x;
        logic signed [COORD_W-1:0] rt_y;
        logic signed [COORD_W-1:0] rb_x;
        logic signed [COORD_W-1:0] rb_y;
        logic signed [COORD_W-1:0] lb_x;
        logic signed [COORD_W-1:0] lb_y;
    } sqh_req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] xu_coef;
        logic signed [COEF_W-1:0] xv_coef;
        logic signed [COEF_W-1:0] x_offset;
        logic signed [COEF_W-1:0] yu_coef;
        logic signed [COEF_W-1:0] yv_coef;
        logic signed [COEF_W-1:0] y_offset;
        logic signed [COEF_W-1:0] persp_u;
        logic signed [COEF_W-1:0] persp_v;
        logic                     degenerate;
    } sqh_result_t;

    typedef struct packed {
        sqh_req_t                 corners;
        logic                     flat;
        logic signed [PROD_W-1:0] den;
        logic signed [PROD_W-1:0] num_g;
        logic signed [PROD_W-1:0] num_h;
    } sqh_work_t;

    typedef struct packed {
        sqh_req_t corners;
        logic     flat;
        logic     degen;
    } sqh_side_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } sqh_qstat_t;

endpackage

>>> rtl/core/sqh_front.sv
module sqh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sqh_pkg::sqh_req_t             req,
    input  logic [sqh_pkg::THR_W-1:0]     thr,
    input  sqh_pkg::sqh_qstat_t           qstat,
    output logic                          push,
    output sqh_pkg::sqh_work_t            push_data
);
    import sqh_pkg::*;

    logic                     v0_reg, v1_reg, v2_reg, v3_reg;
    sqh_req_t                 c0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dx2_reg, dy1_reg, dy2_reg;
    logic signed [RES_W-1:0]  sx_reg, sy_reg;
    logic                     flat1_reg, flat2_reg, flat3_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, na_reg, nb_reg, ma_reg, mb_reg;
    logic signed [PROD_W-1:0] den_reg, numg_reg, numh_reg;

    logic                     accept;
    logic [2:0]               inflight;
    logic [QCNT_W:0]          occupancy;
    logic signed [DIFF_W-1:0] dx1, dx2, dy1, dy2;
    logic signed [RES_W-1:0]  sx, sy;
    logic [RES_W-1:0]         sx_abs, sy_abs;
    logic                     flat;

    // reserve queue room for every request still in the front stages
    assign inflight  = 3'($countones({v0_reg, v1_reg, v2_reg, v3_reg}));
    assign occupancy = {1'b0, qstat.count} + (QCNT_W + 1)'(inflight);
    assign busy      = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept    = start && !busy;

    assign dx1 = DIFF_W'(c0_reg.rt_x) - DIFF_W'(c0_reg.rb_x);
    assign dx2 = DIFF_W'(c0_reg.lb_x) - DIFF_W'(c0_reg.rb_x);
    assign dy1 = DIFF_W'(c0_reg.rt_y) - DIFF_W'(c0_reg.rb_y);
    assign dy2 = DIFF_W'(c0_reg.lb_y) - DIFF_W'(c0_reg.rb_y);
    assign sx  = RES_W'(c0_reg.lt_x) - RES_W'(c0_reg.rt_x)
               + RES_W'(c0_reg.rb_x) - RES_W'(c0_reg.lb_x);
    assign sy  = RES_W'(c0_reg.lt_y) - RES_W'(c0_reg.rt_y)
               + RES_W'(c0_reg.rb_y) - RES_W'(c0_reg.lb_y);
    assign sx_abs = sx[RES_W-1] ? RES_W'(-sx) : RES_W'(sx);
    assign sy_abs = sy[RES_W-1] ? RES_W'(-sy) : RES_W'(sy);
    assign flat   = (sx_abs <= RES_W'(thr)) && (sy_abs <= RES_W'(thr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c0_reg <= req;
        end
        c1_reg    <= c0_reg;
        dx1_reg   <= dx1;
        dx2_reg   <= dx2;
        dy1_reg   <= dy1;
        dy2_reg   <= dy2;
        sx_reg    <= sx;
        sy_reg    <= sy;
        flat1_reg <= flat;

        c2_reg    <= c1_reg;
        flat2_reg <= flat1_reg;
        pa_reg    <= PROD_W'(dx1_reg) * PROD_W'(dy2_reg);
        pb_reg    <= PROD_W'(dy1_reg) * PROD_W'(dx2_reg);
        na_reg    <= PROD_W'(sx_reg) * PROD_W'(dy2_reg);
        nb_reg    <= PROD_W'(sy_reg) * PROD_W'(dx2_reg);
        ma_reg    <= PROD_W'(dx1_reg) * PROD_W'(sy_reg);
        mb_reg    <= PROD_W'(dy1_reg) * PROD_W'(sx_reg);

        c3_reg    <= c2_reg;
        flat3_reg <= flat2_reg;
        den_reg   <= pa_reg - pb_reg;
        numg_reg  <= na_reg - nb_reg;
        numh_reg  <= ma_reg - mb_reg;
    end

    assign push            = v3_reg;
    assign push_data.corners = c3_reg;
    assign push_data.flat    = flat3_reg;
    assign push_data.den     = den_reg;
    assign push_data.num_g   = numg_reg;
    assign push_data.num_h   = numh_reg;

endmodule

>>> rtl/core/sqh_queue.sv
module sqh_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sqh_pkg::sqh_work_t   push_data,
    input  logic                 pop,
    output logic                 pop_valid,
    output sqh_pkg::sqh_work_t   pop_data,
    output sqh_pkg::sqh_qstat_t  qstat
);
    import sqh_pkg::*;

    sqh_work_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign qstat.empty = count_reg == '0;
    assign qstat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign qstat.count = count_reg;
    assign pop_valid   = !qstat.empty;
    assign pop_data    = mem_reg[rd_ptr_reg];
    assign do_pop      = pop && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/sqh_div.sv
module sqh_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [sqh_pkg::PROD_W-1:0] num,
    input  logic signed [sqh_pkg::PROD_W-1:0] den,
    output logic                              out_valid,
    output logic signed [sqh_pkg::COEF_W-1:0] quot
);
    import sqh_pkg::*;

    logic [PROD_W-1:0]    nmag, dmag;
    logic                 v_reg   [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic                 ovf_reg [DIV_STEPS+1];
    logic [DIV_REM_W-1:0] r_reg   [DIV_STEPS+1];
    logic [PROD_W-1:0]    d_reg   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    logic                 vout_reg;
    logic signed [COEF_W-1:0] quot_reg;

    assign nmag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    assign dmag = den[PROD_W-1] ? PROD_W'(-den) : PROD_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= num[PROD_W-1] != den[PROD_W-1];
        ovf_reg[0] <= DIV_REM_W'(nmag) >= (DIV_REM_W'(dmag) << 15);
        r_reg[0]   <= DIV_REM_W'(nmag) << 16;
        d_reg[0]   <= dmag;
        q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [DIV_REM_W-1:0] trial;
        logic                 ge;

        assign trial = DIV_REM_W'(d_reg[k]) << (DIV_STEPS - 1 - k);
        assign ge    = r_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            d_reg[k+1]   <= d_reg[k];
            r_reg[k+1]   <= ge ? r_reg[k] - trial : r_reg[k];
            q_reg[k+1]   <= {q_reg[k][DIV_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ovf_reg[DIV_STEPS])
        begin
            quot_reg <= neg_reg[DIV_STEPS] ? {1'b1, {(COEF_W-1){1'b0}}}
                                           : {1'b0, {(COEF_W-1){1'b1}}};
        end
        else if (neg_reg[DIV_STEPS])
        begin
            quot_reg <= -$signed({1'b0, q_reg[DIV_STEPS]});
        end
        else
        begin
            quot_reg <= $signed({1'b0, q_reg[DIV_STEPS]});
        end
    end

    assign out_valid = vout_reg;
    assign quot      = quot_reg;

endmodule

>>> rtl/core/sqh_back.sv
module sqh_back #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  sqh_pkg::sqh_work_t    pop_data,
    output logic                  pop,
    output logic                  strobe,
    output sqh_pkg::sqh_result_t  result
);
    import sqh_pkg::*;

    localparam int SC = 16 - COORD_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    sqh_side_t                side_reg [DIV_LAT];
    logic                     g_valid, h_valid;
    logic signed [COEF_W-1:0] g, h;
    sqh_side_t                side_in;

    logic                     v1_reg;
    sqh_side_t                s1_reg;
    logic signed [COEF_W-1:0] g1_reg, h1_reg;
    logic signed [PQ_W-1:0]   grx_reg, gry_reg, hlx_reg, hly_reg;

    logic                     strobe_reg;
    sqh_result_t              result_reg;
    sqh_result_t              res;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI)
        begin
            return {1'b0, {(COEF_W-1){1'b1}}};
        end
        if (v < SAT_LO)
        begin
            return {1'b1, {(COEF_W-1){1'b0}}};
        end
        return COEF_W'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] scl(input logic signed [DIFF_W-1:0] d);
        return SUM_W'(d) <<< SC;
    endfunction

    function automatic logic signed [SUM_W-1:0] flr(input logic signed [PQ_W-1:0] p);
        return SUM_W'(p >>> COORD_FRAC_BITS);
    endfunction

    function automatic logic signed [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    assign pop           = pop_valid;
    assign side_in.corners = pop_data.corners;
    assign side_in.flat    = pop_data.flat;
    assign side_in.degen   = !pop_data.flat && (pop_data.den == '0);

    sqh_div u_div_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop_valid),
        .num       (pop_data.num_g),
        .den       (pop_data.den),
        .out_valid (g_valid),
        .quot      (g)
    );

    sqh_div u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop_valid),
        .num       (pop_data.num_h),
        .den       (pop_data.den),
        .out_valid (h_valid),
        .quot      (h)
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= g_valid && h_valid;
            strobe_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= side_reg[DIV_LAT-1];
        g1_reg  <= g;
        h1_reg  <= h;
        grx_reg <= PQ_W'(g) * PQ_W'(side_reg[DIV_LAT-1].corners.rt_x);
        gry_reg <= PQ_W'(g) * PQ_W'(side_reg[DIV_LAT-1].corners.rt_y);
        hlx_reg <= PQ_W'(h) * PQ_W'(side_reg[DIV_LAT-1].corners.lb_x);
        hly_reg <= PQ_W'(h) * PQ_W'(side_reg[DIV_LAT-1].corners.lb_y);
    end

    always_comb
    begin
        res.x_offset   = sat32(scl(DIFF_W'(s1_reg.corners.lt_x)));
        res.y_offset   = sat32(scl(DIFF_W'(s1_reg.corners.lt_y)));
        res.degenerate = 1'b0;
        if (s1_reg.flat)
        begin
            res.xu_coef = sat32(scl(dif(s1_reg.corners.rt_x, s1_reg.corners.lt_x)));
            res.xv_coef = sat32(scl(dif(s1_reg.corners.rb_x, s1_reg.corners.rt_x)));
            res.yu_coef = sat32(scl(dif(s1_reg.corners.rt_y, s1_reg.corners.lt_y)));
            res.yv_coef = sat32(scl(dif(s1_reg.corners.rb_y, s1_reg.corners.rt_y)));
            res.persp_u = '0;
            res.persp_v = '0;
        end
        else
        begin
            res.xu_coef = sat32(scl(dif(s1_reg.corners.rt_x, s1_reg.corners.lt_x))
                                + flr(grx_reg));
            res.xv_coef = sat32(scl(dif(s1_reg.corners.lb_x, s1_reg.corners.lt_x))
                                + flr(hlx_reg));
            res.yu_coef = sat32(scl(dif(s1_reg.corners.rt_y, s1_reg.corners.lt_y))
                                + flr(gry_reg));
            res.yv_coef = sat32(scl(dif(s1_reg.corners.lb_y, s1_reg.corners.lt_y))
                                + flr(hly_reg));
            res.persp_u = g1_reg;
            res.persp_v = h1_reg;
        end
        if (s1_reg.degen)
        begin
            res = '0;
            res.degenerate = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/square_to_quad_homography.sv
// Channel   Handshake              Payload
// request   start / busy           req (sqh_req_t)
// result    strobe, one cycle      result (sqh_result_t)
// config    cfg_we                 cfg_wdata (flat threshold)
//
// One request per cycle while busy is low; each request passes through the front stages,
// the queue, the 31-step pipelined dividers and the back stages to the result ports.
// Reset clears all valid state and sets the threshold to zero.
// The result side cannot stall; busy rises only if the front/back queue would
// run out of room for requests already in flight.
`include "square_to_quad_homography_macros.svh"

module square_to_quad_homography #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sqh_pkg::sqh_req_t             req,
    output logic                          strobe,
    output sqh_pkg::sqh_result_t          result,
    input  logic                          cfg_we,
    input  logic [sqh_pkg::THR_W-1:0]     cfg_wdata
);
    import sqh_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             push, pop, pop_valid;
    sqh_work_t        push_data, pop_data;
    sqh_qstat_t       qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    sqh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .thr       (thr_reg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    sqh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    sqh_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .strobe    (strobe),
        .result    (result)
    );

    `SQH_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !qstat.full, "queue overflow")
    `SQH_ASSERT_IMPLY(a_degen_zero, clk, rst_n, strobe && result.degenerate,
        result.xu_coef == 0 && result.persp_u == 0 && result.persp_v == 0, "degenerate nonzero")
    `SQH_ASSERT_NEXT(a_queue_drain, clk, rst_n, pop_valid && !push,
        qstat.count < QCNT_W'(QUEUE_DEPTH), "queue not draining")

endmodule

>>> dv/square_to_quad_homography_checker.sv
module square_to_quad_homography_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  sqh_pkg::sqh_req_t           req,
    input  logic                        strobe,
    input  sqh_pkg::sqh_result_t        result,
    input  logic                        cfg_we,
    input  logic [sqh_pkg::THR_W-1:0]   cfg_wdata,
    input  logic                        drain,
    output int                          errors,
    output int                          pending
);
    import sqh_pkg::*;

    sqh_result_t      coef_q[$];
    logic [THR_W-1:0] flat_thr;
    int               mismatches;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic sqh_result_t map_quad(sqh_req_t c, logic [THR_W-1:0] thr);
        sqh_result_t r;
        longint ltx, lty, rtx, rty, rbx, rby, lbx, lby;
        longint sx, sy, dx1, dx2, dy1, dy2, den, g, h, lim;
        ltx = longint'(c.lt_x); lty = longint'(c.lt_y);
        rtx = longint'(c.rt_x); rty = longint'(c.rt_y);
        rbx = longint'(c.rb_x); rby = longint'(c.rb_y);
        lbx = longint'(c.lb_x); lby = longint'(c.lb_y);
        lim = longint'(thr);
        sx = ltx - rtx + rbx - lbx;
        sy = lty - rty + rby - lby;
        r = '0;
        if ((sx < 0 ? -sx : sx) <= lim && (sy < 0 ? -sy : sy) <= lim)
        begin
            r.xu_coef  = COEF_W'(clamp32((rtx - ltx) * 4096));
            r.xv_coef  = COEF_W'(clamp32((rbx - rtx) * 4096));
            r.x_offset = COEF_W'(clamp32(ltx * 4096));
            r.yu_coef  = COEF_W'(clamp32((rty - lty) * 4096));
            r.yv_coef  = COEF_W'(clamp32((rby - rty) * 4096));
            r.y_offset = COEF_W'(clamp32(lty * 4096));
            return r;
        end
        dx1 = rtx - rbx; dx2 = lbx - rbx;
        dy1 = rty - rby; dy2 = lby - rby;
        den = dx1 * dy2 - dy1 * dx2;
        if (den == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        g = clamp32(((sx * dy2 - sy * dx2) <<< 16) / den);
        h = clamp32(((dx1 * sy - dy1 * sx) <<< 16) / den);
        r.xu_coef  = COEF_W'(clamp32((rtx - ltx) * 4096 + ((g * rtx) >>> 4)));
        r.xv_coef  = COEF_W'(clamp32((lbx - ltx) * 4096 + ((h * lbx) >>> 4)));
        r.x_offset = COEF_W'(clamp32(ltx * 4096));
        r.yu_coef  = COEF_W'(clamp32((rty - lty) * 4096 + ((g * rty) >>> 4)));
        r.yv_coef  = COEF_W'(clamp32((lby - lty) * 4096 + ((h * lby) >>> 4)));
        r.y_offset = COEF_W'(clamp32(lty * 4096));
        r.persp_u  = COEF_W'(g);
        r.persp_v  = COEF_W'(h);
        return r;
    endfunction

    assign pending = coef_q.size();
    assign errors  = mismatches + (drain ? coef_q.size() : 0);

    always @(posedge clk or negedge rst_n)
    begin
        sqh_result_t exp_r;
        if (!rst_n)
        begin
            flat_thr   = '0;
            mismatches = 0;
            coef_q.delete();
        end
        else
        begin
            if (cfg_we)
                flat_thr = cfg_wdata;
            if (start && !busy)
                coef_q.push_back(map_quad(req, flat_thr));
            if (strobe)
            begin
                if (coef_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    exp_r = coef_q.pop_front();
                    if (result !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", exp_r, result);
                    end
                end
            end
        end
    end

endmodule

>>> dv/square_to_quad_homography_tb.sv
module square_to_quad_homography_tb;
    import sqh_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    sqh_req_t         req;
    logic             strobe;
    sqh_result_t      result;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;
    logic             drain;
    logic             took;
    int               errors;
    int               pending;
    int               cycles;

    square_to_quad_homography dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    square_to_quad_homography_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .drain(drain), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        took <= start && !busy;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(sqh_req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(negedge clk);
        while (!took);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [15:0] near(int lo, int hi);
        return 16'($urandom_range(hi - lo) + lo);
    endfunction

    function automatic sqh_req_t make_quad();
        sqh_req_t q;
        int       span;
        q = sqh_req_t'({$urandom, $urandom, $urandom, $urandom});
        span = ($urandom_range(3) == 0) ? 16000 : 400;
        case ($urandom_range(9))
            0, 1: ;
            2, 3, 4:
            begin
                q.lt_x = near(-span, span); q.lt_y = near(-span, span);
                q.rt_x = near(-span, span); q.rt_y = near(-span, span);
                q.rb_x = near(-span, span); q.rb_y = near(-span, span);
                q.lb_x = near(-span, span); q.lb_y = near(-span, span);
            end
            5, 6, 7:
            begin
                q.lt_x = near(-span, span); q.lt_y = near(-span, span);
                q.rt_x = near(-span, span); q.rt_y = near(-span, span);
                q.lb_x = near(-span, span); q.lb_y = near(-span, span);
                q.rb_x = q.rt_x + q.lb_x - q.lt_x + near(-4, 4);
                q.rb_y = q.rt_y + q.lb_y - q.lt_y + near(-4, 4);
            end
            8:
            begin
                q.rb_x = q.rt_x;
                q.rb_y = q.rt_y;
            end
            default:
            begin
                q.rt_x = 16'sh7fff - near(0, 3); q.lt_x = -16'sh7fff + near(0, 3);
                q.rb_y = 16'sh7fff - near(0, 3); q.lb_y = -16'sh7fff + near(0, 3);
            end
        endcase
        return q;
    endfunction

    task automatic random_phase(int count, int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(4) + 1) @(negedge clk);
            end
            send_request(make_quad());
        end
    endtask

    initial
    begin
        sqh_req_t d;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        drain     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request('0);
        send_request({8{16'sh7fff}});
        send_request({8{16'sh8000}});
        d = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_request(d);
        d = '{16'sh0, 16'sh0, 16'sh10, 16'sh0, 16'sh10, 16'sh10, 16'sh0, 16'sh10};
        send_request(d);
        d = '{16'sh0, 16'sh0, 16'sh40, 16'sh8, 16'sh30, 16'sh38, 16'sh4, 16'sh20};
        send_request(d);
        d = '{16'sh0, 16'sh0, 16'sh10, 16'sh10, 16'sh10, 16'sh10, 16'sh5, 16'sh30};
        send_request(d);
        d = '{16'sh0, 16'sh0, 16'sh1, 16'sh0, 16'sh2, 16'sh0, 16'sh3, 16'sh1};
        send_request(d);
        d = '{16'sh7000, 16'sh8000, 16'sh8001, 16'sh7fff,
              16'sh7fff, 16'sh8001, 16'sh8000, 16'sh7ffe};
        send_request(d);
        d = '{16'sh0, 16'sh0, 16'sh1000, 16'sh0, 16'sh1001, 16'sh1000, 16'sh0, 16'sh1000};
        send_request(d);
        write_threshold(15'h7fff);
        send_request(d);
        send_request({8{16'sh7fff}});
        d = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_request(d);
        write_threshold(15'd2);

        random_phase(430, 17);
        write_threshold(15'($urandom_range(32767)));
        random_phase(20, 17);
        write_threshold(15'd0);
        random_phase(420, 82);
        write_threshold(15'd3);
        random_phase(430, 0);

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        drain <= 1'b1;
        @(negedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
